// ===== rtl/core/fcw_pkg.sv =====
// ---------------------------------------------------------------------------
// fcw_pkg
// Shared types and constants for the front-coded word list decoder.
// ---------------------------------------------------------------------------
package fcw_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 5;
  localparam int LEN_W   = 6;
  localparam int CLASS_W = 12;
  localparam int GROUP_W = 12;
  localparam int INFO_W  = 16;

  localparam logic [BYTE_W-1:0] CHAR_MASK = 8'h7f;
  localparam int                END_BIT   = 7;
  localparam logic [BYTE_W-1:0] NUL_CHAR  = 8'h00;

  typedef enum logic [5:0] {
    ST_KEEP   = 6'b000001,
    ST_SUFFIX = 6'b000010,
    ST_INFO0  = 6'b000100,
    ST_INFO1  = 6'b001000,
    ST_INFO2  = 6'b010000,
    ST_EMIT   = 6'b100000
  } fcw_state_t;

  // Commands from the controller; the *_acc bits pulse when an item is taken.
  typedef struct packed {
    logic keep_acc;
    logic suffix_acc;
    logic info0_acc;
    logic info1_acc;
    logic info2_acc;
    logic emit;
  } fcw_cmd_t;

  // Status back from the datapath.
  typedef struct packed {
    logic bad_keep;
    logic keep_full;
    logic suffix_end;
    logic emit_done;
    logic out_free;
  } fcw_stat_t;

endpackage

// ===== rtl/core/fcw_if.sv =====
// ---------------------------------------------------------------------------
// fcw_in_if / fcw_out_if
// Valid/ready channels for the encoded byte stream and the decoded characters.
// ---------------------------------------------------------------------------
interface fcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fcw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  word_char;
  logic [4:0]  char_position;
  logic [5:0]  word_length;
  logic [11:0] word_class;
  logic [11:0] word_group;
  logic        last_of_word;
  logic        bad_keep_count;
  logic        truncated;

  modport source (output valid, output word_char, output char_position,
                  output word_length, output word_class, output word_group,
                  output last_of_word, output bad_keep_count, output truncated,
                  input ready);
  modport sink   (input valid, input word_char, input char_position,
                  input word_length, input word_class, input word_group,
                  input last_of_word, input bad_keep_count, input truncated,
                  output ready);
endinterface

// ===== rtl/core/fcw_ctrl.sv =====
// ---------------------------------------------------------------------------
// fcw_ctrl
// Entry parsing state machine: keep count, suffix, three info bytes, readout.
// ---------------------------------------------------------------------------
module fcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcw_pkg::fcw_stat_t stat,
  output fcw_pkg::fcw_cmd_t  cmd
);
  import fcw_pkg::*;

  fcw_state_t state_r, state_nxt;
  logic       acc;

  always_comb begin
    case (state_r)
      ST_KEEP:   in_ready = stat.out_free;
      ST_SUFFIX: in_ready = 1'b1;
      ST_INFO0:  in_ready = 1'b1;
      ST_INFO1:  in_ready = 1'b1;
      ST_INFO2:  in_ready = 1'b1;
      ST_EMIT:   in_ready = 1'b0;
      default:   in_ready = 1'b0;
    endcase
  end

  assign acc = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.keep_acc   = acc && (state_r == ST_KEEP);
    cmd.suffix_acc = acc && (state_r == ST_SUFFIX);
    cmd.info0_acc  = acc && (state_r == ST_INFO0);
    cmd.info1_acc  = acc && (state_r == ST_INFO1);
    cmd.info2_acc  = acc && (state_r == ST_INFO2);
    cmd.emit       = (state_r == ST_EMIT);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_KEEP: begin
        if (acc && !stat.bad_keep) begin
          state_nxt = stat.keep_full ? ST_INFO0 : ST_SUFFIX;
        end
      end
      ST_SUFFIX: begin
        if (acc && stat.suffix_end) begin
          state_nxt = ST_INFO0;
        end
      end
      ST_INFO0: if (acc) state_nxt = ST_INFO1;
      ST_INFO1: if (acc) state_nxt = ST_INFO2;
      ST_INFO2: if (acc) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.emit_done) begin
          state_nxt = ST_KEEP;
        end
      end
      default: state_nxt = ST_KEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_KEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/fcw_dp.sv =====
// ---------------------------------------------------------------------------
// fcw_dp
// Word store, length and info registers, readout pipeline and output register.
// ---------------------------------------------------------------------------
module fcw_dp #(
  parameter int WORD_MAX = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [7:0]         data_byte,
  input  fcw_pkg::fcw_cmd_t  cmd,
  output fcw_pkg::fcw_stat_t stat,
  fcw_out_if.source          out_ch
);
  import fcw_pkg::*;

  localparam int LW = $clog2(WORD_MAX + 1);
  localparam int AW = $clog2(WORD_MAX);
  localparam logic [BYTE_W-1:0] MAX_B = BYTE_W'(WORD_MAX);
  localparam logic [LW-1:0]     MAX_L = LW'(WORD_MAX);

  logic [BYTE_W-1:0] mem [WORD_MAX];

  logic              mode_r;
  logic [LW-1:0]     word_len_r, word_len_nxt;
  logic              trunc_r, trunc_nxt;
  logic [INFO_W-1:0] info_hi_r;
  logic [CLASS_W-1:0] cls_r;
  logic [GROUP_W-1:0] grp_r;

  logic [LW-1:0]     rd_cnt_r;
  logic              rd_v_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [LW-1:0]     st_pos_r;
  logic              st_last_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] o_char_r;
  logic [POS_W-1:0]  o_pos_r;
  logic [LEN_W-1:0]  o_len_r;
  logic [CLASS_W-1:0] o_cls_r;
  logic [GROUP_W-1:0] o_grp_r;
  logic              o_last_r, o_bad_r, o_trunc_r;

  logic [LW-1:0]     len_inc;
  logic [LW-1:0]     total;
  logic [7:0]        len8, pos8;
  logic              we;
  logic [BYTE_W-1:0] wdata;
  logic              out_free, bad_keep, suffix_end, issue, move, load_bad;

  assign out_free = !out_valid_r || out_ch.ready;
  assign len_inc  = word_len_r + LW'(1);
  assign bad_keep = data_byte > 8'(word_len_r);
  assign total    = (word_len_r == '0) ? LW'(1) : word_len_r;

  // Keep count load and suffix handling: store, length step and end of suffix for each mode.
  always_comb begin
    we           = 1'b0;
    wdata        = data_byte;
    suffix_end   = 1'b0;
    word_len_nxt = word_len_r;
    trunc_nxt    = trunc_r;
    if (cmd.keep_acc && !bad_keep) begin
      word_len_nxt = data_byte[LW-1:0];
      trunc_nxt    = data_byte >= MAX_B;
    end else if (cmd.suffix_acc) begin
      if (mode_r) begin
        if (data_byte == NUL_CHAR) begin
          suffix_end = 1'b1;
        end else begin
          we           = 1'b1;
          word_len_nxt = len_inc;
          if (len_inc >= MAX_L) begin
            suffix_end = 1'b1;
            trunc_nxt  = 1'b1;
          end
        end
      end else begin
        we           = 1'b1;
        wdata        = data_byte & CHAR_MASK;
        word_len_nxt = len_inc;
        if (data_byte[END_BIT]) begin
          suffix_end = 1'b1;
        end else if (len_inc >= MAX_L) begin
          suffix_end = 1'b1;
          trunc_nxt  = 1'b1;
        end
      end
    end
  end

  // Readout: one read issued per cycle while the staging slot drains.
  assign issue    = cmd.emit && (rd_cnt_r != total) && (!rd_v_r || out_free);
  assign move     = rd_v_r && out_free;
  assign load_bad = cmd.keep_acc && bad_keep;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[word_len_r[AW-1:0]] <= wdata;
    end
    if (issue) begin
      rd_data_r <= mem[rd_cnt_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.info2_acc) begin
      cls_r <= info_hi_r[15:4];
      grp_r <= {info_hi_r[3:0], data_byte};
    end
    if (issue) begin
      st_pos_r  <= rd_cnt_r;
      st_last_r <= (rd_cnt_r + LW'(1)) == total;
    end
  end

  assign len8 = 8'(word_len_r);
  assign pos8 = 8'(st_pos_r);

  always_ff @(posedge clk) begin
    if (load_bad) begin
      o_char_r  <= '0;
      o_pos_r   <= '0;
      o_len_r   <= '0;
      o_cls_r   <= '0;
      o_grp_r   <= '0;
      o_last_r  <= 1'b0;
      o_bad_r   <= 1'b1;
      o_trunc_r <= 1'b0;
    end else if (move) begin
      // An empty word still reads slot zero, but gives a zero character.
      o_char_r  <= (word_len_r == '0) ? NUL_CHAR : rd_data_r;
      o_pos_r   <= pos8[POS_W-1:0];
      o_len_r   <= len8[LEN_W-1:0];
      o_cls_r   <= cls_r;
      o_grp_r   <= grp_r;
      o_last_r  <= st_last_r;
      o_bad_r   <= 1'b0;
      o_trunc_r <= trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      word_len_r  <= '0;
      trunc_r     <= 1'b0;
      info_hi_r   <= '0;
      rd_cnt_r    <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      word_len_r <= word_len_nxt;
      trunc_r    <= trunc_nxt;
      if (cmd.info0_acc) info_hi_r[15:8] <= data_byte;
      if (cmd.info1_acc) info_hi_r[7:0]  <= data_byte;
      if (cmd.info2_acc) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + LW'(1);
      end
      if (issue) begin
        rd_v_r <= 1'b1;
      end else if (move) begin
        rd_v_r <= 1'b0;
      end
      if (load_bad || move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.bad_keep   = bad_keep;
    stat.keep_full  = data_byte >= MAX_B;
    stat.suffix_end = suffix_end;
    stat.emit_done  = (rd_cnt_r == total) && !rd_v_r;
    stat.out_free   = out_free;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.word_char      = o_char_r;
  assign out_ch.char_position  = o_pos_r;
  assign out_ch.word_length    = o_len_r;
  assign out_ch.word_class     = o_cls_r;
  assign out_ch.word_group     = o_grp_r;
  assign out_ch.last_of_word   = o_last_r;
  assign out_ch.bad_keep_count = o_bad_r;
  assign out_ch.truncated      = o_trunc_r;

endmodule

// ===== rtl/core/front_coded_word_list_decoder_top.sv =====
// ---------------------------------------------------------------------------
// front_coded_word_list_decoder_top
// Decodes a front-coded word list byte stream into per-character results.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one byte of the encoded list per item: a keep count, the
//   suffix characters, then three info bytes. cfg_we/cfg_wdata set the
//   suffix mode (0: bit 7 ends the word, 1: a zero byte ends it).
//   out_ch gives one item per character of a finished word, with its
//   position, length, class, group and flags; an empty word gives one item.
//   A keep count above the stored length gives a single flagged item.
// Timing:
//   Each byte is taken when in_ch is ready; a keep count waits for a free
//   output slot. After the third info byte the word store is read one
//   character per cycle while out_ch does not stall, through a registered
//   memory port into a staging register and then the output register; no
//   input item is taken until the readout of the word ends.
// Reset and stall:
//   rst_n (synchronous) clears the parser, the stored length and the mode.
//   The store itself is not cleared. A stalled out_ch holds its item; the
//   readout pauses, and a keep count waits until the output slot frees.
// ---------------------------------------------------------------------------
module front_coded_word_list_decoder_top #(
  parameter int WORD_MAX = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  fcw_in_if.sink    in_ch,
  fcw_out_if.source out_ch
);
  import fcw_pkg::*;

  fcw_cmd_t  cmd;
  fcw_stat_t stat;
  logic      ready;

  assign in_ch.ready = ready;

  fcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcw_dp #(
    .WORD_MAX (WORD_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .data_byte (in_ch.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/sv/fcw_word_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fcw_word_checker
// Watches the byte stream, the mode register and the character stream of the
// front-coded word list decoder, decodes the bytes on its own and compares
// every character item with the oldest one it has worked out.
// ---------------------------------------------------------------------------
module fcw_word_checker #(
  parameter int WORD_MAX = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  fcw_in_if                   in_ch,
  fcw_out_if                  out_ch,
  input  logic                end_check,
  output int                  errors,
  output int                  pending,
  output int                  stored_len,
  output fcw_pkg::fcw_state_t parse_phase
);
  import fcw_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [BYTE_W-1:0]  ch;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
    logic [CLASS_W-1:0] cls;
    logic [GROUP_W-1:0] grp;
    logic               last;
    logic               bad_keep;
    logic               trunc;
  } char_result_t;

  char_result_t      expected_chars[$];
  logic [BYTE_W-1:0] word_buf [WORD_MAX];
  int                word_len;
  logic [INFO_W-1:0] info_hi;
  logic              trunc_flag;
  logic              mode_nul;
  fcw_state_t        phase;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_REPORTS)
      $display("%0t fcw check: %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic queue_result(input char_result_t r);
    expected_chars.insert(expected_chars.size(), r);
  endtask

  // Works out the character items that one accepted byte causes.
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    char_result_t      r;
    logic [23:0]       info;
    int                n;
    case (phase)
      ST_KEEP: begin
        if (int'(b) > word_len) begin
          // The byte is dropped; a single flagged item with all else zero.
          r = '0;
          r.bad_keep = 1'b1;
          queue_result(r);
        end else begin
          word_len   = int'(b);
          trunc_flag = 1'b0;
          if (word_len >= WORD_MAX) begin
            trunc_flag = 1'b1;
            phase      = ST_INFO0;
          end else begin
            phase = ST_SUFFIX;
          end
        end
      end
      ST_SUFFIX: begin
        if (mode_nul) begin
          if (b == NUL_CHAR) begin
            phase = ST_INFO0;
          end else begin
            if (word_len < WORD_MAX) word_buf[word_len] = b;
            word_len++;
            if (word_len >= WORD_MAX) begin
              trunc_flag = 1'b1;
              phase      = ST_INFO0;
            end
          end
        end else begin
          if (word_len < WORD_MAX) word_buf[word_len] = b & CHAR_MASK;
          word_len++;
          if (b[END_BIT]) begin
            phase = ST_INFO0;
          end else if (word_len >= WORD_MAX) begin
            trunc_flag = 1'b1;
            phase      = ST_INFO0;
          end
        end
      end
      ST_INFO0: begin
        info_hi = {b, 8'h00};
        phase   = ST_INFO1;
      end
      ST_INFO1: begin
        info_hi[7:0] = b;
        phase        = ST_INFO2;
      end
      default: begin
        info  = {info_hi, b};
        phase = ST_KEEP;
        n     = (word_len > WORD_MAX) ? WORD_MAX : word_len;
        r       = '0;
        r.cls   = info[23:12];
        r.grp   = info[11:0];
        r.trunc = trunc_flag;
        if (n == 0) begin
          r.last = 1'b1;
          queue_result(r);
        end else begin
          for (int i = 0; i < n; i++) begin
            r.ch   = word_buf[i];
            r.pos  = POS_W'(i);
            r.len  = LEN_W'(n);
            r.last = (i == n - 1);
            queue_result(r);
          end
        end
      end
    endcase
  endtask

  task automatic check_char();
    char_result_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("character item with nothing expected", 32'(out_ch.word_char), 0);
    end else begin
      want = expected_chars.pop_front();
      if (out_ch.word_char !== want.ch)
        report_mismatch("word_char", 32'(out_ch.word_char), 32'(want.ch));
      if (out_ch.char_position !== want.pos)
        report_mismatch("char_position", 32'(out_ch.char_position), 32'(want.pos));
      if (out_ch.word_length !== want.len)
        report_mismatch("word_length", 32'(out_ch.word_length), 32'(want.len));
      if (out_ch.word_class !== want.cls)
        report_mismatch("word_class", 32'(out_ch.word_class), 32'(want.cls));
      if (out_ch.word_group !== want.grp)
        report_mismatch("word_group", 32'(out_ch.word_group), 32'(want.grp));
      if (out_ch.last_of_word !== want.last)
        report_mismatch("last_of_word", 32'(out_ch.last_of_word), 32'(want.last));
      if (out_ch.bad_keep_count !== want.bad_keep)
        report_mismatch("bad_keep_count", 32'(out_ch.bad_keep_count),
                        32'(want.bad_keep));
      if (out_ch.truncated !== want.trunc)
        report_mismatch("truncated", 32'(out_ch.truncated), 32'(want.trunc));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = ST_KEEP;
      word_len   = 0;
      info_hi    = '0;
      trunc_flag = 1'b0;
      mode_nul   = 1'b0;
      errors     = 0;
      expected_chars.delete();
    end else begin
      if (cfg_we) mode_nul = cfg_wdata;
      // New bytes first, so that expectations are queued before any compare.
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) check_char();
      if (end_check && expected_chars.size() != 0)
        report_mismatch("character items never seen", 32'(expected_chars.size()), 0);
    end
    pending     = expected_chars.size();
    stored_len  = word_len;
    parse_phase = phase;
  end

endmodule

// ===== tb/sv/tb_front_coded_word_list_decoder_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_front_coded_word_list_decoder_top
// Feeds the decoder a short directed byte stream and then random word lists
// in both suffix modes, with random gaps on the byte side and random stalls
// on the character side. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_front_coded_word_list_decoder_top;
  import fcw_pkg::*;

  localparam int WORD_MAX      = 32;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = WORD_MAX + 8;
  localparam int PHASE_BYTES   = 100;
  localparam int IDLE_PCT      = 27;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       end_check;
  int         errors;
  int         pending;
  int         stored_len;
  fcw_state_t parse_phase;
  int         idle_pct = IDLE_PCT;
  int         bytes_sent = 0;
  logic       mode_nul = 1'b0;

  fcw_in_if  in_ch ();
  fcw_out_if out_ch ();

  front_coded_word_list_decoder_top #(
    .WORD_MAX (WORD_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  fcw_word_checker #(
    .WORD_MAX (WORD_MAX)
  ) word_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .end_check   (end_check),
    .errors      (errors),
    .pending     (pending),
    .stored_len  (stored_len),
    .parse_phase (parse_phase)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_front_coded_word_list_decoder_top: errors");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is
  // taken, with valid still high.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_info(input logic [23:0] info);
    send_byte(info[23:16]);
    send_byte(info[15:8]);
    send_byte(info[7:0]);
  endtask

  // Closes whatever entry the parser is in, so the next byte is a keep count.
  task automatic realign();
    while (parse_phase != ST_KEEP) begin
      if (parse_phase == ST_SUFFIX)
        send_byte(mode_nul ? NUL_CHAR : 8'(8'h80 | $urandom_range(127)));
      else
        send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic set_mode(input logic nul_mode);
    realign();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= nul_mode;
    @(negedge clk);
    cfg_we   <= 1'b0;
    mode_nul  = nul_mode;
  endtask

  // One well-formed entry against the current stored word.
  task automatic send_word();
    int         keep;
    int         room;
    int         n;
    logic       term;
    logic [7:0] b;
    case ($urandom_range(3))
      0:       keep = stored_len;
      1:       keep = 0;
      default: keep = $urandom_range(stored_len);
    endcase
    room = WORD_MAX - keep;
    n    = ($urandom_range(3) == 0) ? room : $urandom_range(6);
    if (n > room) n = room;
    // In bit-7 mode a suffix takes at least one byte unless the kept part fills the word.
    if (!mode_nul && room > 0 && n == 0) n = 1;
    term = (n < room) || ($urandom_range(1) == 1);
    send_byte(8'(keep));
    for (int i = 0; i < n; i++) begin
      if (mode_nul) b = 8'($urandom_range(255, 1));
      else          b = {(i == n - 1) && term, 7'($urandom_range(127))};
      send_byte(b);
    end
    if (mode_nul && n < room) send_byte(NUL_CHAR);
    send_info(24'($urandom));
  endtask

  initial begin
    int start;
    int pick;
    int drain;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    end_check       = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: keep counts above the stored length, a zero character with
    // the end bit, extreme info values, then an empty word in zero-byte mode.
    set_mode(1'b0);
    send_byte(8'h01);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);
    send_info(24'hffffff);
    send_byte(8'h01);
    send_byte(8'h7f);
    send_byte(8'hff);
    send_info(24'h000000);
    send_byte(8'h04);
    set_mode(1'b1);
    send_byte(8'h00);
    send_byte(NUL_CHAR);
    send_info(24'h123456);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(NUL_CHAR);
    send_info(24'ha55a0f);

    // Random word lists, alternating modes; the third phase runs with no gaps.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 2) ? 0 : IDLE_PCT;
      set_mode(ph[0]);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          realign();
          send_word();
        end else if (pick < 85) begin
          realign();
          send_byte(8'(stored_len + 1 + $urandom_range(254 - stored_len)));
        end else if (pick < 93) begin
          // Entry cut short: random bytes follow a valid keep count.
          realign();
          send_byte(8'($urandom_range(stored_len)));
          repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
        end
      end
    end
    idle_pct = IDLE_PCT;
    realign();

    in_ch.valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    end_check <= 1'b1;
    @(negedge clk);
    end_check <= 1'b0;
    @(negedge clk);
    if (errors == 0) begin
      $display("tb_front_coded_word_list_decoder_top: clean");
    end else begin
      $display("tb_front_coded_word_list_decoder_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fcw_pkg.sv
rtl/core/fcw_if.sv
rtl/core/fcw_ctrl.sv
rtl/core/fcw_dp.sv
rtl/core/front_coded_word_list_decoder_top.sv
tb/sv/fcw_word_checker.sv
tb/sv/tb_front_coded_word_list_decoder_top.sv
